@@ hw/rtl/pli_pkg.sv @@
`timescale 1ns / 1ps

package pli_pkg;

  localparam int MaxKnots = 16;

  localparam int CntW  = 5;
  localparam int IdxW  = 4;
  localparam int TimeW = 16;
  localparam int ValW  = 32;
  localparam int FracW = 8;
  localparam int OutW  = ValW + FracW;
  localparam int ProdW = ValW + TimeW;
  localparam int NumW  = ProdW + FracW;

  // quotient bits resolved per divider stage
  localparam int DivBits   = 4;
  localparam int DivStages = (OutW + DivBits - 1) / DivBits;
  localparam int QuoW      = DivStages * DivBits;

  typedef enum logic {
    CmdLoad = 1'b0,
    CmdEval = 1'b1
  } cmd_e;

endpackage

@@ hw/rtl/piecewise_linear_interpolator_top.sv @@
`timescale 1ns / 1ps

// A query's result is registered in the query, select, span and multiply stages,
// then in 11 divider stages incl. dividend setup, then in the output register.
// Throughput: one item per cycle; a stall at the output halts the whole pipe.
// Loads produce no result and update the knot table at their input transfer.
// Reset clears the pipe valids and sets knots_q to 1; the knot table
// is not cleared and is undefined until written.
module piecewise_linear_interpolator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [pli_pkg::IdxW-1:0]      knot_index_i,
  input  logic [pli_pkg::TimeW-1:0]     knot_time_i,
  input  logic [pli_pkg::ValW-1:0]      knot_value_i,
  input  logic [pli_pkg::TimeW-1:0]     query_time_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pli_pkg::OutW-1:0]      interpolated_value_o,
  input  logic                          cfg_we_i,
  input  logic [pli_pkg::CntW-1:0]      cfg_wdata_i
);

  localparam int NK = pli_pkg::MaxKnots;
  localparam int DS = pli_pkg::DivStages;
  localparam int TW = pli_pkg::TimeW;
  localparam int VW = pli_pkg::ValW;
  localparam int QW = pli_pkg::QuoW;
  localparam int NW = pli_pkg::NumW;
  localparam int OW = pli_pkg::OutW;
  localparam int FW = pli_pkg::FracW;
  localparam int PW = pli_pkg::ProdW;
  localparam int CW = pli_pkg::CntW;

  logic en;
  logic in_xfer;

  logic [CW-1:0] knots_q;
  logic [TW-1:0] time_q [NK];
  logic [VW-1:0] value_q [NK];

  // stage a: registered query
  logic          a_valid_q;
  logic [TW-1:0] a_query_q;

  // stage b: selected segment
  logic          b_valid_q, b_valid_d;
  logic          b_flat_q, b_flat_d;
  logic [TW-1:0] b_query_q, b_query_d;
  logic [TW-1:0] b_t0_q, b_t0_d;
  logic [TW-1:0] b_t1_q, b_t1_d;
  logic [VW-1:0] b_y0_q, b_y0_d;
  logic [VW-1:0] b_y1_q, b_y1_d;

  // stage c: spans
  logic          c_valid_q;
  logic          c_up_q, c_up_d;
  logic [VW-1:0] c_diff_q, c_diff_d;
  logic [TW-1:0] c_dq_q, c_dq_d;
  logic [TW-1:0] c_dt_q, c_dt_d;
  logic [VW-1:0] c_y0_q;

  // stage d: product
  logic          d_valid_q;
  logic          d_up_q;
  logic [PW-1:0] d_prod_q, d_prod_d;
  logic [TW-1:0] d_dt_q;
  logic [VW-1:0] d_y0_q;

  // divider stages
  logic          dv_valid_q [DS+1];
  logic          dv_up_q    [DS+1];
  logic [VW-1:0] dv_y0_q    [DS+1];
  logic [TW-1:0] dv_dt_q    [DS+1];
  logic [TW-1:0] dv_rem_q   [DS+1];
  logic [TW-1:0] dv_rem_d   [DS+1];
  logic [QW-1:0] dv_work_q  [DS+1];
  logic [QW-1:0] dv_work_d  [DS+1];

  logic          out_valid_q;
  logic [OW-1:0] out_q, out_d;

  assign en          = ~out_valid_q | out_ready_i;
  assign in_ready_o  = en;
  assign in_xfer     = in_valid_i & en;
  assign out_valid_o = out_valid_q;
  assign interpolated_value_o = out_q;

  // configuration and knot table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knots_q <= CW'(1);
    end else if (cfg_we_i) begin
      knots_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NK; i++) begin
      if (in_xfer && (cmd_i == pli_pkg::CmdLoad) && (32'(knot_index_i) == 32'(i))) begin
        time_q[i]  <= knot_time_i;
        value_q[i] <= knot_value_i;
      end
    end
  end

  // segment select
  always_comb begin
    logic [CW-1:0] n_eff;
    logic [CW-1:0] nm1;
    logic [NK-1:0] hit;
    logic [NK-1:0] sel;
    logic [TW-1:0] t_last;
    logic [VW-1:0] v_last;
    logic [VW-1:0] v_seg;
    logic          lo;
    logic          hi;
    n_eff = knots_q;
    if (knots_q == '0) begin
      n_eff = CW'(1);
    end else if (32'(knots_q) > NK) begin
      n_eff = CW'(NK);
    end
    nm1    = n_eff - CW'(1);
    t_last = '0;
    v_last = '0;
    v_seg  = '0;
    b_t0_d = '0;
    b_t1_d = '0;
    b_y1_d = '0;
    for (int i = 0; i < NK; i++) begin
      hit[i] = (time_q[i] <= a_query_q) && (i < 32'(nm1));
    end
    for (int i = 0; i < NK; i++) begin
      sel[i] = hit[i] & ~|(hit >> (i + 1));
      if (32'(nm1) == i) begin
        t_last = t_last | time_q[i];
        v_last = v_last | value_q[i];
      end
      if (sel[i]) begin
        b_t0_d = b_t0_d | time_q[i];
        v_seg  = v_seg | value_q[i];
      end
    end
    for (int i = 0; i < NK - 1; i++) begin
      if (sel[i]) begin
        b_t1_d = b_t1_d | time_q[i+1];
        b_y1_d = b_y1_d | value_q[i+1];
      end
    end
    lo = a_query_q < time_q[0];
    hi = a_query_q >= t_last;
    priority if (lo) begin
      b_y0_d = value_q[0];
    end else if (hi) begin
      b_y0_d = v_last;
    end else begin
      b_y0_d = v_seg;
    end
    b_flat_d  = lo | hi;
    b_query_d = a_query_q;
    b_valid_d = a_valid_q;
  end

  // spans
  always_comb begin
    c_up_d = b_flat_q | (b_y1_q >= b_y0_q);
    if (b_flat_q) begin
      c_diff_d = '0;
      c_dq_d   = '0;
      c_dt_d   = TW'(1);
    end else begin
      c_diff_d = c_up_d ? (b_y1_q - b_y0_q) : (b_y0_q - b_y1_q);
      c_dq_d   = b_query_q - b_t0_q;
      c_dt_d   = b_t1_q - b_t0_q;
    end
  end

  assign d_prod_d = PW'(c_diff_q) * PW'(c_dq_q);

  // dividend (drop rounded up on a falling segment), then restoring
  // division, DivBits quotient bits per stage
  always_comb begin
    logic [NW-1:0] num;
    logic [TW-1:0] rem_v;
    logic [QW-1:0] work_v;
    logic [TW:0]   trial_v;
    num = {d_prod_q, FW'(0)};
    if (!d_up_q) begin
      num = num + NW'(d_dt_q - TW'(1));
    end
    dv_rem_d[0]  = num[NW-1 -: TW];
    dv_work_d[0] = QW'(num[NW-TW-1:0]);
    for (int k = 0; k < DS; k++) begin
      rem_v  = dv_rem_q[k];
      work_v = dv_work_q[k];
      for (int j = 0; j < pli_pkg::DivBits; j++) begin
        trial_v = {rem_v, work_v[QW-1]};
        work_v  = {work_v[QW-2:0], 1'b0};
        if (trial_v >= {1'b0, dv_dt_q[k]}) begin
          trial_v   = trial_v - {1'b0, dv_dt_q[k]};
          work_v[0] = 1'b1;
        end
        rem_v = trial_v[TW-1:0];
      end
      dv_rem_d[k+1]  = rem_v;
      dv_work_d[k+1] = work_v;
    end
  end

  always_comb begin
    if (dv_up_q[DS]) begin
      out_d = {dv_y0_q[DS], FW'(0)} + OW'(dv_work_q[DS]);
    end else begin
      out_d = {dv_y0_q[DS], FW'(0)} - OW'(dv_work_q[DS]);
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k <= DS; k++) begin
        dv_valid_q[k] <= 1'b0;
      end
    end else if (en) begin
      a_valid_q     <= in_valid_i && (cmd_i == pli_pkg::CmdEval);
      b_valid_q     <= b_valid_d;
      c_valid_q     <= b_valid_q;
      d_valid_q     <= c_valid_q;
      dv_valid_q[0] <= d_valid_q;
      for (int k = 1; k <= DS; k++) begin
        dv_valid_q[k] <= dv_valid_q[k-1];
      end
      out_valid_q <= dv_valid_q[DS];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_query_q <= query_time_i;
      b_flat_q  <= b_flat_d;
      b_query_q <= b_query_d;
      b_t0_q    <= b_t0_d;
      b_t1_q    <= b_t1_d;
      b_y0_q    <= b_y0_d;
      b_y1_q    <= b_y1_d;
      c_up_q    <= c_up_d;
      c_diff_q  <= c_diff_d;
      c_dq_q    <= c_dq_d;
      c_dt_q    <= c_dt_d;
      c_y0_q    <= b_y0_q;
      d_up_q    <= c_up_q;
      d_prod_q  <= d_prod_d;
      d_dt_q    <= c_dt_q;
      d_y0_q    <= c_y0_q;
      dv_up_q[0]   <= d_up_q;
      dv_y0_q[0]   <= d_y0_q;
      dv_dt_q[0]   <= d_dt_q;
      dv_rem_q[0]  <= dv_rem_d[0];
      dv_work_q[0] <= dv_work_d[0];
      for (int k = 1; k <= DS; k++) begin
        dv_up_q[k]   <= dv_up_q[k-1];
        dv_y0_q[k]   <= dv_y0_q[k-1];
        dv_dt_q[k]   <= dv_dt_q[k-1];
        dv_rem_q[k]  <= dv_rem_d[k];
        dv_work_q[k] <= dv_work_d[k];
      end
      out_q <= out_d;
    end
  end

endmodule
